// ===== sv/gcpw_pkg.sv =====
package gcpw_pkg;

	localparam int SCREEN_WIDTH  = 800;
	localparam int SCREEN_HEIGHT = 480;

	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int COORD_W = 13;
	localparam int INDEX_W = 19;
	localparam int CFG_W   = 24;

	localparam int SCREEN_W_BITS = $clog2(SCREEN_WIDTH + 1);
	localparam int IDX_RAW_W     = (COORD_W - 1) + SCREEN_W_BITS + 1;
	localparam int IDX_SUM_W     = (IDX_RAW_W > INDEX_W) ? IDX_RAW_W : INDEX_W;

	typedef enum logic [2:0] {
		REG_TEXT_COLOR   = 3'd0,
		REG_LEFT_EDGE    = 3'd1,
		REG_TOP_EDGE     = 3'd2,
		REG_GLYPH_WIDTH  = 3'd3,
		REG_GLYPH_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		chan_t  coverage;
		coord_t sx;
		coord_t sy;
		logic   glyph_end;
	} item_t;

endpackage

// ===== sv/gcpw_color_scale.sv =====
module gcpw_color_scale
	import gcpw_pkg::*;
(
	input  color_t color,
	input  chan_t  coverage,
	output color_t scaled
);

	localparam int NUM_CHAN = COLOR_W / CHAN_W;

	// floor(x / 255) for x up to 255 * 255: (x + (x >> 8) + 1) >> 8
	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
		logic [2*CHAN_W-1:0] prod;
		logic [2*CHAN_W:0]   sum;

		assign prod = color[i*CHAN_W +: CHAN_W] * coverage;
		assign sum  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]}
			+ {{(2*CHAN_W){1'b0}}, 1'b1};
		assign scaled[i*CHAN_W +: CHAN_W] = sum[2*CHAN_W-1:CHAN_W];
	end

endmodule

// ===== sv/glyph_coverage_pixel_writer.sv =====
// Antialiased glyph writer. Coverage bytes enter in row-major order, one transfer per
// cycle while in_ready is high; column and row counters step against glyph_width and
// glyph_height (zero acts as one) and clear after the glyph_end pixel. Every input gives
// exactly one result: the text color scaled per channel by coverage/255 (floor) and
// the frame-buffer index (top_edge + row) * SCREEN_WIDTH + left_edge + column. Zero
// coverage gives write_enable low; nonzero coverage outside the screen gives off_screen
// high with write_enable low. Throughput is one pixel per cycle, set by the two register
// stages (position capture, then scaling and index multiply), stalling together on out_ready.
// Users must write registers via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module glyph_coverage_pixel_writer
	import gcpw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAN_W-1:0]   coverage,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                write_enable,
	output logic [INDEX_W-1:0]  pixel_index,
	output logic [COLOR_W-1:0]  pixel_color,
	output logic                off_screen,
	output logic                glyph_end,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	color_t                  text_color_q;
	logic signed [11:0]      left_edge_q;
	logic signed [11:0]      top_edge_q;
	logic [7:0]              glyph_width_q;
	logic [7:0]              glyph_height_q;
	logic [7:0]              column_q;
	logic [7:0]              row_q;

	item_t                   item_s1;
	logic                    valid_s1;

	logic                    in_xfer;
	logic                    out_adv;
	logic                    s1_adv;
	logic [7:0]              gw_last;
	logic [7:0]              gh_last;
	logic                    last_col;
	logic                    last_row;
	item_t                   item_in;

	logic                    nonzero;
	logic                    off;
	logic                    we;
	logic [IDX_SUM_W-1:0]    idx_sum;
	color_t                  scaled;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q   <= '1;
			left_edge_q    <= '0;
			top_edge_q     <= '0;
			glyph_width_q  <= 8'd1;
			glyph_height_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEXT_COLOR:   text_color_q   <= cfg_data[COLOR_W-1:0];
				REG_LEFT_EDGE:    left_edge_q    <= cfg_data[11:0];
				REG_TOP_EDGE:     top_edge_q     <= cfg_data[11:0];
				REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data[7:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign out_adv  = !out_valid || out_ready;
	assign s1_adv   = valid_s1 && out_adv;
	assign in_ready = !valid_s1 || out_adv;
	assign in_xfer  = in_valid && in_ready;

	assign gw_last  = (glyph_width_q == 8'd0) ? 8'd0 : glyph_width_q - 8'd1;
	assign gh_last  = (glyph_height_q == 8'd0) ? 8'd0 : glyph_height_q - 8'd1;
	assign last_col = column_q >= gw_last;
	assign last_row = row_q >= gh_last;

	always_comb begin
		item_in.coverage  = coverage;
		item_in.sx        = coord_t'(left_edge_q) + coord_t'({1'b0, column_q});
		item_in.sy        = coord_t'(top_edge_q) + coord_t'({1'b0, row_q});
		item_in.glyph_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (in_xfer) begin
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? 8'd0 : row_q + 8'd1;
			end else begin
				column_q <= column_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item_in;
		end
	end

	gcpw_color_scale u_scale (
		.color    (text_color_q),
		.coverage (item_s1.coverage),
		.scaled   (scaled)
	);

	assign nonzero = item_s1.coverage != '0;
	assign off = item_s1.sx[COORD_W-1] || item_s1.sy[COORD_W-1]
		|| ({1'b0, item_s1.sx[COORD_W-2:0]} >= COORD_W'(SCREEN_WIDTH))
		|| ({1'b0, item_s1.sy[COORD_W-2:0]} >= COORD_W'(SCREEN_HEIGHT));
	assign we = nonzero && !off;
	assign idx_sum = IDX_SUM_W'(item_s1.sy[COORD_W-2:0]) * IDX_SUM_W'(SCREEN_WIDTH)
		+ IDX_SUM_W'(item_s1.sx[COORD_W-2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			write_enable <= we;
			pixel_index  <= we ? idx_sum[INDEX_W-1:0] : '0;
			pixel_color  <= we ? scaled : '0;
			off_screen   <= nonzero && off;
			glyph_end    <= item_s1.glyph_end;
		end
	end

	a_we_off_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_enable && off_screen))
		else $error("write_enable and off_screen both set");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> pixel_index == '0 && pixel_color == '0)
		else $error("suppressed write carries nonzero fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 item lost under stall");

	a_counters_home: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && item_in.glyph_end |=> column_q == '0 && row_q == '0)
		else $error("counters not cleared after glyph end");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gcpw_pkg::*;

	typedef struct packed {
		logic               wr;
		logic [INDEX_W-1:0] index;
		logic [COLOR_W-1:0] color;
		logic               off;
		logic               last;
	} pixel_write_t;

	typedef struct packed {
		logic               set_cfg;
		logic [COLOR_W-1:0] color;
		logic [11:0]        left;
		logic [11:0]        top;
		logic [7:0]         w;
		logic [7:0]         h;
		logic [CHAN_W-1:0]  cov;
		logic               typed;
		pixel_write_t       want;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CHAN_W-1:0]   coverage;
	logic                out_valid;
	logic                out_ready;
	logic                write_enable;
	logic [INDEX_W-1:0]  pixel_index;
	logic [COLOR_W-1:0]  pixel_color;
	logic                off_screen;
	logic                glyph_end;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// shadow of the glyph registers and position counters
	logic [COLOR_W-1:0]  cfg_color = 24'hFFFFFF;
	logic signed [11:0]  cfg_left = '0;
	logic signed [11:0]  cfg_top = '0;
	logic [7:0]          cfg_width = 8'd1;
	logic [7:0]          cfg_height = 8'd1;
	logic [7:0]          col_pos = '0;
	logic [7:0]          row_pos = '0;

	pixel_write_t        pending_writes[$];
	int                  pixels_in = 0;
	int                  errors = 0;
	bit                  idle_on = 1'b1;
	logic                typed_now;
	pixel_write_t        typed_want;

	step_row_t plan [26] = '{
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b1, '{1'b1, 19'd0, 24'hFFFFFF, 1'b0, 1'b1}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h00, 1'b1, '{1'b0, 19'd0, 24'h0, 1'b0, 1'b1}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h01, 1'b1, '{1'b1, 19'd0, 24'h010101, 1'b0, 1'b1}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h80, 1'b1, '{1'b1, 19'd0, 24'h808080, 1'b0, 1'b1}},
		'{1'b1, 24'h000000, 12'd799, 12'd479, 8'd2, 8'd2, 8'hFF, 1'b1,
			'{1'b1, 19'd383999, 24'h0, 1'b0, 1'b0}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b1, '{1'b0, 19'd0, 24'h0, 1'b1, 1'b0}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h7F, 1'b1, '{1'b0, 19'd0, 24'h0, 1'b1, 1'b0}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h00, 1'b1, '{1'b0, 19'd0, 24'h0, 1'b0, 1'b1}},
		'{1'b1, 24'h123456, 12'h800, 12'h800, 8'd0, 8'd0, 8'h55, 1'b1,
			'{1'b0, 19'd0, 24'h0, 1'b1, 1'b1}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h00, 1'b1, '{1'b0, 19'd0, 24'h0, 1'b0, 1'b1}},
		'{1'b1, 24'hFFFFFF, 12'h7FF, 12'h7FF, 8'd255, 8'd255, 8'hFF, 1'b1,
			'{1'b0, 19'd0, 24'h0, 1'b1, 1'b0}},
		'{1'b1, 24'hA5C33C, 12'hFFF, 12'h0, 8'd3, 8'd1, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h40, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b1, 24'h808080, 12'h0, 12'hFFF, 8'd1, 8'd2, 8'hC0, 1'b1,
			'{1'b0, 19'd0, 24'h0, 1'b1, 1'b0}},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hC0, 1'b0, '0},
		'{1'b1, 24'hFFFFFF, 12'd10, 12'd10, 8'd4, 8'd4, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b1, 24'hFFFFFF, 12'd10, 12'd10, 8'd2, 8'd2, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b1, 24'h3C5AA5, 12'd5, 12'd5, 8'd1, 8'd4, 8'hFF, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'h9A, 1'b0, '0},
		'{1'b0, 24'h0, 12'h0, 12'h0, 8'd0, 8'd0, 8'hFF, 1'b0, '0},
		'{1'b1, 24'h3C5AA5, 12'd5, 12'd5, 8'd1, 8'd2, 8'hFF, 1'b0, '0}
	};

	glyph_coverage_pixel_writer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coverage     (coverage),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.pixel_index  (pixel_index),
		.pixel_color  (pixel_color),
		.off_screen   (off_screen),
		.glyph_end    (glyph_end),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pixel_write_t next_pixel_write(input logic [CHAN_W-1:0] cov);
		pixel_write_t p;
		logic [7:0]   gw;
		logic [7:0]   gh;
		logic         at_col_end;
		logic         at_row_end;
		int           sx;
		int           sy;
		int           r;
		int           g;
		int           b;
		p = '0;
		gw = (cfg_width == 8'd0) ? 8'd1 : cfg_width;
		gh = (cfg_height == 8'd0) ? 8'd1 : cfg_height;
		at_col_end = (col_pos >= gw - 8'd1);
		at_row_end = (row_pos >= gh - 8'd1);
		sx = int'(cfg_left) + int'(col_pos);
		sy = int'(cfg_top) + int'(row_pos);
		if (cov != 8'd0) begin
			if (sx < 0 || sx >= SCREEN_WIDTH || sy < 0 || sy >= SCREEN_HEIGHT) begin
				p.off = 1'b1;
			end else begin
				r = (int'(cfg_color[23:16]) * int'(cov)) / 255;
				g = (int'(cfg_color[15:8]) * int'(cov)) / 255;
				b = (int'(cfg_color[7:0]) * int'(cov)) / 255;
				p.wr = 1'b1;
				p.index = INDEX_W'(sy * SCREEN_WIDTH + sx);
				p.color = {8'(r), 8'(g), 8'(b)};
			end
		end
		p.last = at_col_end && at_row_end;
		if (at_col_end) begin
			col_pos = '0;
			row_pos = at_row_end ? 8'd0 : row_pos + 8'd1;
		end else begin
			col_pos = col_pos + 8'd1;
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("%0t ns: %s got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	// transfers on both channels, checked at the rising edge
	always @(posedge clk) begin
		pixel_write_t got;
		pixel_write_t want;
		pixel_write_t guess;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready) begin
				got = {write_enable, pixel_index, pixel_color, off_screen, glyph_end};
				if (pending_writes.size() == 0) begin
					report_mismatch("unexpected transfer", 32'(got.index), 32'h0);
				end else begin
					want = pending_writes.pop_front();
					if (got.wr !== want.wr)
						report_mismatch("write_enable", 32'(got.wr), 32'(want.wr));
					if (got.index !== want.index)
						report_mismatch("pixel_index", 32'(got.index), 32'(want.index));
					if (got.color !== want.color)
						report_mismatch("pixel_color", 32'(got.color), 32'(want.color));
					if (got.off !== want.off)
						report_mismatch("off_screen", 32'(got.off), 32'(want.off));
					if (got.last !== want.last)
						report_mismatch("glyph_end", 32'(got.last), 32'(want.last));
				end
			end
			if (in_valid && in_ready === 1'b1) begin
				guess = next_pixel_write(coverage);
				pending_writes.push_back(typed_now ? typed_want : guess);
				pixels_in++;
			end
		end
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_pixel(input logic [CHAN_W-1:0] cov, input logic typed,
			input pixel_write_t want);
		int target;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		target = pixels_in + 1;
		in_valid <= 1'b1;
		coverage <= cov;
		typed_now <= typed;
		typed_want <= want;
		do @(negedge clk); while (pixels_in < target);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_writes.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic set_glyph_regs(input logic [COLOR_W-1:0] color, input logic [11:0] left,
			input logic [11:0] top, input logic [7:0] w, input logic [7:0] h);
		logic [23:0] junk;
		junk = $urandom;
		write_reg(REG_TEXT_COLOR, color);
		write_reg(REG_LEFT_EDGE, {junk[23:12], left});
		write_reg(REG_TOP_EDGE, {junk[11:0], top});
		write_reg(REG_GLYPH_WIDTH, {junk[15:0], w});
		write_reg(REG_GLYPH_HEIGHT, {junk[23:8], h});
		cfg_we <= 1'b0;
		cfg_color = color;
		cfg_left = left;
		cfg_top = top;
		cfg_width = w;
		cfg_height = h;
		@(negedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] rand_cov();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'd0;
			3: return 8'd255;
			4: return 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// often near the screen borders so glyphs straddle them
	function automatic logic [11:0] pick_edge(input int span);
		case ($urandom_range(0, 3))
			0: return 12'($urandom);
			1: return 12'($urandom_range(0, 8) - 4);
			2: return 12'(span - 8 + $urandom_range(0, 10));
			default: return 12'($urandom_range(0, span - 1));
		endcase
	endfunction

	initial begin
		step_row_t          row;
		logic [COLOR_W-1:0] color;
		logic [7:0]         w;
		logic [7:0]         h;
		int                 cells;
		int                 count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coverage = '0;
		typed_now = 1'b0;
		typed_want = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(plan); i++) begin
			row = plan[i];
			if (row.set_cfg) begin
				drain_pipe();
				set_glyph_regs(row.color, row.left, row.top, row.w, row.h);
			end
			send_pixel(row.cov, row.typed, row.want);
		end

		while (pixels_in < 1530) begin
			idle_on = (pixels_in < 1250) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 19))
				0: begin
					w = 8'd255;
					h = 8'($urandom_range(0, 1));
				end
				1: begin
					w = 8'($urandom_range(0, 1));
					h = 8'd255;
				end
				default: begin
					w = 8'($urandom_range(0, 6));
					h = 8'($urandom_range(0, 6));
				end
			endcase
			case ($urandom_range(0, 5))
				0: color = 24'h000000;
				1: color = 24'hFFFFFF;
				default: color = 24'($urandom);
			endcase
			drain_pipe();
			set_glyph_regs(color, pick_edge(SCREEN_WIDTH), pick_edge(SCREEN_HEIGHT), w, h);
			cells = (w == 8'd0 ? 1 : int'(w)) * (h == 8'd0 ? 1 : int'(h));
			count = (cells > 50) ? cells : cells * $urandom_range(1, 3);
			// partial glyph: the next glyph starts from mid-bitmap counters
			if ($urandom_range(0, 5) == 0)
				count = $urandom_range(1, cells + 3);
			repeat (count) send_pixel(rand_cov(), 1'b0, '0);
		end

		idle_on = 1'b0;
		drain_pipe();
		repeat (8) @(negedge clk);
		if (errors == 0 && pending_writes.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
